### rtl/msseq_pkg.sv
package msseq_pkg;

   localparam int MAX_STEPS = 256;
   localparam int IDX_W     = $clog2(MAX_STEPS);
   localparam int CNT_W     = $clog2(MAX_STEPS + 1);

   localparam int PROG_W = 17;
   localparam logic [PROG_W-1:0] PROG_ONE = PROG_W'(65536);

   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [1:0] AXIS_NONE = 2'd0;
   localparam logic [1:0] AXIS_X    = 2'd1;
   localparam logic [1:0] AXIS_Y    = 2'd2;

   typedef enum logic [1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_TICK   = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SETUP,
      ST_DIVIDE,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]          axis;
      logic signed [15:0]  distance;
      logic signed [15:0]  speed;
   } step_entry_type;

   typedef struct packed {
      logic        start;
      logic [15:0] numer;
      logic [15:0] denom;
   } div_req_type;

   function automatic logic [15:0] mag16(logic signed [15:0] v);
      logic [15:0] u;
      u = v;
      return v[15] ? 16'(~u + 16'd1) : u;
   endfunction

endpackage

### rtl/msseq_divider.sv
module msseq_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  msseq_pkg::div_req_type    div_req,
   output logic                      div_done,
   output logic [15:0]               div_quotient
);
   import msseq_pkg::*;

   // Fractional divide: numer < denom, quotient = (numer << 16) / denom,
   // one quotient bit per cycle.
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          den_ff, den_in;
   logic [15:0]          quo_ff, quo_in;
   logic                 done_ff, done_in;
   logic [17:0]          trial;

   assign trial = {1'b0, rem_ff, 1'b0} - {2'b00, den_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         cnt_in = DIV_CNT_W'(DIV_STEPS);
         rem_in = div_req.numer;
         den_in = div_req.denom;
         quo_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (!trial[17]) begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = {rem_ff[14:0], 1'b0};
            quo_in = {quo_ff[14:0], 1'b0};
         end
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = quo_ff;

endmodule

### rtl/motion_step_sequencer.sv
// Motion step sequencer.
// req_* channel: one item per handshake. func APPEND stores {axis, distance,
// speed} at the end of a 256-entry step table, TICK plays the active step,
// CLEAR empties the table and rewinds. Every item produces exactly one rsp_*
// item: current motion, active step index, finished and append_refused.
// csr_* channel: writes loop_enable; always ready, write only while idle.
// Append, clear and unused codes go from accept straight to the DONE state;
// a tick passes LOAD, SETUP, DIVIDE, UPDATE and DONE, where DIVIDE runs the
// bit-serial divider that forms |speed| * 65536 / |distance| one quotient bit
// per cycle (ticks with zero distance or |speed| >= |distance| skip DIVIDE).
// One item is in flight at a time: req_ready is high only when the sequencer
// is idle, so a new item is taken only once the last one has left DONE.
// A finished result sits in the rsp output register; a new item may be
// accepted meanwhile, but its result waits until rsp_ready takes the old one.
// Reset (synchronous, active high) empties the table, zeroes step, progress,
// motion and loop_enable and drops rsp_valid. Table contents are not cleared;
// entries beyond the fill count are played as a blank step.
module motion_step_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [1:0]         req_axis,
   input  logic signed [15:0] req_distance,
   input  logic signed [15:0] req_speed,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_move_x,
   output logic signed [15:0] rsp_move_y,
   output logic [7:0]         rsp_step_index,
   output logic               rsp_finished,
   output logic               rsp_append_refused,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_loop_enable
);
   import msseq_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]    entry_count_ff, entry_count_in;
   logic [IDX_W-1:0]    current_step_ff, current_step_in;
   logic [PROG_W-1:0]   progress_ff, progress_in;
   logic signed [15:0]  move_x_ff, move_x_in;
   logic signed [15:0]  move_y_ff, move_y_in;
   logic                loop_enable_ff;
   logic                refused_ff, refused_in;
   step_entry_type      step_ff, step_in;
   logic [15:0]         delta_ff, delta_in;
   logic                sat_ff, sat_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]  rsp_move_x_ff, rsp_move_y_ff;
   logic [7:0]          rsp_step_index_ff;
   logic                rsp_finished_ff, rsp_append_refused_ff;
   logic                rsp_load;

   step_entry_type      step_table [MAX_STEPS];
   step_entry_type      rd_data_ff;
   logic                table_we;

   logic                accept;
   func_type            func;
   step_entry_type      fetched;
   logic [15:0]         smag, dmag;
   logic [PROG_W:0]     sum;
   logic                full;
   logic [CNT_W-1:0]    next_step;
   div_req_type         div_req;
   logic                div_done;
   logic [15:0]         div_quotient;

   assign accept    = req_valid && req_ready;
   assign func      = func_type'(req_func);
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // past-the-count steps play as a blank step
   assign fetched = (CNT_W'(current_step_ff) < entry_count_ff) ? rd_data_ff : '0;
   assign smag    = mag16(fetched.speed);
   assign dmag    = mag16(fetched.distance);

   assign sum       = {1'b0, progress_ff} + (PROG_W + 1)'(delta_ff);
   assign full      = sat_ff || (sum >= (PROG_W + 1)'(PROG_ONE));
   assign next_step = CNT_W'(current_step_ff) + 1'b1;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   msseq_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .div_req      (div_req),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (func == FUNC_TICK) ? ST_LOAD : ST_DONE;
            end
         end
         ST_LOAD:  state_in = ST_SETUP;
         ST_SETUP: begin
            if (dmag == '0 || smag >= dmag) begin
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      entry_count_in  = entry_count_ff;
      current_step_in = current_step_ff;
      progress_in     = progress_ff;
      move_x_in       = move_x_ff;
      move_y_in       = move_y_ff;
      refused_in      = refused_ff;
      step_in         = step_ff;
      delta_in        = delta_ff;
      sat_in          = sat_ff;
      table_we        = 1'b0;
      div_req.start   = 1'b0;
      div_req.numer   = smag;
      div_req.denom   = dmag;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               refused_in = 1'b0;
               case (func)
                  FUNC_APPEND: begin
                     if (entry_count_ff == CNT_W'(MAX_STEPS)) begin
                        refused_in = 1'b1;
                     end else begin
                        table_we       = 1'b1;
                        entry_count_in = entry_count_ff + 1'b1;
                     end
                  end
                  FUNC_CLEAR: begin
                     entry_count_in  = '0;
                     current_step_in = '0;
                     progress_in     = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SETUP: begin
            step_in       = fetched;
            delta_in      = '0;
            sat_in        = (dmag != '0) && (smag >= dmag);
            div_req.start = (dmag != '0) && (smag < dmag);
         end
         ST_DIVIDE: begin
            if (div_done) begin
               delta_in = div_quotient;
            end
         end
         ST_UPDATE: begin
            progress_in = full ? PROG_ONE : sum[PROG_W-1:0];
            case (step_ff.axis)
               AXIS_X: move_x_in = step_ff.speed;
               AXIS_Y: move_y_in = step_ff.speed;
               default: begin
                  move_x_in = '0;
                  move_y_in = '0;
               end
            endcase
            if (full) begin
               if (next_step < entry_count_ff) begin
                  progress_in     = '0;
                  current_step_in = current_step_ff + 1'b1;
               end else if (loop_enable_ff) begin
                  progress_in     = '0;
                  current_step_in = '0;
               end else begin
                  move_x_in = '0;
                  move_y_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (table_we) begin
         step_table[entry_count_ff[IDX_W-1:0]] <= {req_axis, req_distance, req_speed};
      end
      rd_data_ff <= step_table[current_step_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         entry_count_ff  <= '0;
         current_step_ff <= '0;
         progress_ff     <= '0;
         move_x_ff       <= '0;
         move_y_ff       <= '0;
         loop_enable_ff  <= 1'b0;
         refused_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         entry_count_ff  <= entry_count_in;
         current_step_ff <= current_step_in;
         progress_ff     <= progress_in;
         move_x_ff       <= move_x_in;
         move_y_ff       <= move_y_in;
         refused_ff      <= refused_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            loop_enable_ff <= csr_loop_enable;
         end
      end
      step_ff  <= step_in;
      delta_ff <= delta_in;
      sat_ff   <= sat_in;
      if (rsp_load) begin
         rsp_move_x_ff         <= move_x_ff;
         rsp_move_y_ff         <= move_y_ff;
         rsp_step_index_ff     <= 8'(current_step_ff);
         rsp_finished_ff       <= (progress_ff >= PROG_ONE);
         rsp_append_refused_ff <= refused_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_move_x         = rsp_move_x_ff;
   assign rsp_move_y         = rsp_move_y_ff;
   assign rsp_step_index     = rsp_step_index_ff;
   assign rsp_finished       = rsp_finished_ff;
   assign rsp_append_refused = rsp_append_refused_ff;

endmodule

### rtl/msseq_checker.sv
module msseq_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_move_x,
   input logic signed [15:0] rsp_move_y,
   input logic               rsp_finished
);

   // one item in flight: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accepted item");

   // holding at the end of the table means no motion
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_move_x == 16'sd0 && rsp_move_y == 16'sd0)
      else $error("finished item reports nonzero motion");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_move_x) && $stable(rsp_move_y))
      else $error("stalled rsp item changed or dropped");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind motion_step_sequencer msseq_checker u_msseq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_move_x   (rsp_move_x),
   .rsp_move_y   (rsp_move_y),
   .rsp_finished (rsp_finished)
);
